// ===== hw/rtl/psoq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psoq_pkg
// Shared types and constants of the photo sensor output qualifier: register
// widths, register indexes, reset values and the structs between modules.
// ----------------------------------------------------------------------------
package psoq_pkg;

    // Fixed field widths
    localparam int SAMPLES_PER_CYCLE = 8;
    localparam int LEVEL_W           = 12;
    localparam int CONFIRM_W         = 4;
    localparam int DELAY_W           = 16;
    localparam int RUN_W             = 5;
    localparam int CFG_ADDR_W        = 3;
    localparam int CFG_DATA_W        = 16;

    // Register reset values
    localparam logic [LEVEL_W-1:0]   DETECT_LEVEL_RST    = 12'd2500;
    localparam logic [LEVEL_W-1:0]   RELEASE_LEVEL_RST   = 12'd2600;
    localparam logic [LEVEL_W-1:0]   ALARM_ON_LEVEL_RST  = 12'd2650;
    localparam logic [LEVEL_W-1:0]   ALARM_OFF_LEVEL_RST = 12'd2700;
    localparam logic [CONFIRM_W-1:0] CONFIRM_COUNT_RST   = 4'd3;
    localparam logic [DELAY_W-1:0]   OFF_DELAY_LIMIT_RST = 16'd220;

    // Register indexes on the configuration port
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DETECT_LEVEL    = 3'd0,
        REG_RELEASE_LEVEL   = 3'd1,
        REG_ALARM_ON_LEVEL  = 3'd2,
        REG_ALARM_OFF_LEVEL = 3'd3,
        REG_CONFIRM_COUNT   = 3'd4,
        REG_OFF_DELAY_LIMIT = 3'd5
    } psoq_reg_idx_t;

    // Configuration as seen by the qualifier core
    typedef struct packed {
        logic [LEVEL_W-1:0]   detect_level;
        logic [LEVEL_W-1:0]   release_level;
        logic [LEVEL_W-1:0]   alarm_on_level;
        logic [LEVEL_W-1:0]   alarm_off_level;
        logic [CONFIRM_W-1:0] confirm_count;
        logic [DELAY_W-1:0]   off_delay_limit;
    } psoq_cfg_t;

    // Status flags of one result
    typedef struct packed {
        logic out_level;
        logic alarm;
        logic detect_state;
    } psoq_flags_t;

endpackage

// ===== hw/rtl/psoq_mean.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psoq_mean
// Sums the samples of one measurement cycle and divides by eight with
// truncation (a shift).
// ----------------------------------------------------------------------------
module psoq_mean
    import psoq_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  logic [SAMPLES_PER_CYCLE-1:0][SAMPLE_BITS-1:0] samples,
    output logic [SAMPLE_BITS-1:0]                        mean
);

    localparam int SUM_W = SAMPLE_BITS + $clog2(SAMPLES_PER_CYCLE);

    logic [SUM_W-1:0] sum;

    // Eight-input sum
    always_comb
    begin
        sum = '0;
        for (int k = 0; k < SAMPLES_PER_CYCLE; k++)
        begin
            sum = sum + SUM_W'(samples[k]);
        end
    end

    // Divide by eight
    assign mean = sum[SUM_W-1:$clog2(SAMPLES_PER_CYCLE)];

endmodule

// ===== hw/rtl/psoq_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psoq_core
// Detect vote counters, alarm hysteresis and off-delay timing. State moves
// on each step; the flags show the state after the step.
// ----------------------------------------------------------------------------
module psoq_core
    import psoq_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [SAMPLE_BITS-1:0] mean,
    input  logic                   light_dark_select,
    input  logic                   off_delay_enable,
    input  psoq_cfg_t              cfg,
    output psoq_flags_t            flags
);

    localparam int CMP_W = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

    logic               detect_reg,   detect_next;
    logic [RUN_W-1:0]   detect_run_reg,  detect_run_next;
    logic [RUN_W-1:0]   release_run_reg, release_run_next;
    logic               alarm_reg,    alarm_next;
    logic               pin_reg,      pin_next;
    logic               delay_active_reg, delay_active_next;
    logic [DELAY_W-1:0] delay_count_reg,  delay_count_next;

    logic [CMP_W-1:0]   mean_x;
    logic               rel_vote;
    logic               det_vote;
    logic [RUN_W-1:0]   rel_run_v;
    logic [RUN_W-1:0]   det_run_v;
    logic [RUN_W-1:0]   confirm_x;
    logic               want;
    logic [DELAY_W-1:0] count_inc;

    assign mean_x    = CMP_W'(mean);
    assign confirm_x = RUN_W'(cfg.confirm_count);
    assign count_inc = delay_count_reg + DELAY_W'(1);

    // Votes: release wins when both levels are met
    assign rel_vote = mean_x >= CMP_W'(cfg.release_level);
    assign det_vote = !rel_vote && (mean_x <= CMP_W'(cfg.detect_level));

    // Run counters after the vote
    always_comb
    begin
        rel_run_v = release_run_reg;
        det_run_v = detect_run_reg;
        if (rel_vote)
        begin
            rel_run_v = release_run_reg + RUN_W'(1);
            det_run_v = '0;
        end
        else if (det_vote)
        begin
            det_run_v = detect_run_reg + RUN_W'(1);
            rel_run_v = '0;
        end
    end

    // Confirmation, release checked first
    always_comb
    begin
        detect_next      = detect_reg;
        release_run_next = rel_run_v;
        detect_run_next  = det_run_v;
        priority if (rel_run_v > confirm_x)
        begin
            detect_next      = 1'b0;
            release_run_next = '0;
        end
        else if (det_run_v > confirm_x)
        begin
            detect_next     = 1'b1;
            detect_run_next = '0;
        end
    end

    // Alarm hysteresis, set wins on overlap
    always_comb
    begin
        alarm_next = alarm_reg;
        priority if (mean_x <= CMP_W'(cfg.alarm_on_level))
            alarm_next = 1'b1;
        else if (mean_x >= CMP_W'(cfg.alarm_off_level))
            alarm_next = 1'b0;
    end

    assign want = (light_dark_select == detect_next);

    // Output level with off-delay
    always_comb
    begin
        pin_next          = pin_reg;
        delay_active_next = delay_active_reg;
        delay_count_next  = delay_count_reg;
        if (off_delay_enable)
        begin
            if (want && !delay_active_reg)
            begin
                pin_next = 1'b1;
            end
            else
            begin
                delay_active_next = 1'b1;
                delay_count_next  = count_inc;
                if (count_inc > cfg.off_delay_limit)
                begin
                    pin_next          = 1'b0;
                    delay_active_next = 1'b0;
                    delay_count_next  = '0;
                end
            end
        end
        else
        begin
            pin_next = want;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detect_reg       <= 1'b0;
            detect_run_reg   <= '0;
            release_run_reg  <= '0;
            alarm_reg        <= 1'b0;
            pin_reg          <= 1'b0;
            delay_active_reg <= 1'b0;
            delay_count_reg  <= '0;
        end
        else if (step)
        begin
            detect_reg       <= detect_next;
            detect_run_reg   <= detect_run_next;
            release_run_reg  <= release_run_next;
            alarm_reg        <= alarm_next;
            pin_reg          <= pin_next;
            delay_active_reg <= delay_active_next;
            delay_count_reg  <= delay_count_next;
        end
    end

    assign flags.out_level    = pin_next;
    assign flags.alarm        = alarm_next;
    assign flags.detect_state = detect_next;

endmodule

// ===== hw/rtl/photo_sensor_output_qualifier_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// photo_sensor_output_qualifier_unit
// Path: an accepted transaction is held in the input register and then moves
// into the result register, where out_valid goes high; a stalled output holds it.
// Throughput: one transaction per cycle while the output is not stalled; mean,
// compares and state update fit between the input register and the result register.
// Reset: asynchronous; config returns to defaults, valid flags and qualifier state clear.
// ----------------------------------------------------------------------------
module photo_sensor_output_qualifier_unit
    import psoq_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // input channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] sample_0,
    input  logic [SAMPLE_BITS-1:0] sample_1,
    input  logic [SAMPLE_BITS-1:0] sample_2,
    input  logic [SAMPLE_BITS-1:0] sample_3,
    input  logic [SAMPLE_BITS-1:0] sample_4,
    input  logic [SAMPLE_BITS-1:0] sample_5,
    input  logic [SAMPLE_BITS-1:0] sample_6,
    input  logic [SAMPLE_BITS-1:0] sample_7,
    input  logic                   light_dark_select,
    input  logic                   off_delay_enable,
    // output channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   out_level,
    output logic                   alarm,
    output logic                   detect_state,
    output logic [LEVEL_W-1:0]     mean_value
);

    psoq_cfg_t cfg_reg;

    logic                                         s1_valid_reg;
    logic [SAMPLES_PER_CYCLE-1:0][SAMPLE_BITS-1:0] s1_sample_reg;
    logic                                         s1_ld_reg;
    logic                                         s1_odly_reg;

    logic               res_valid_reg;
    psoq_flags_t        res_flags_reg;
    logic [LEVEL_W-1:0] res_mean_reg;

    logic                   advance;
    logic                   s1_load;
    logic [SAMPLE_BITS-1:0] mean;
    psoq_flags_t            flags;

    // Handshake control
    assign advance  = s1_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && res_valid_reg && out_stall;
    assign s1_load  = in_valid && !in_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.detect_level    <= DETECT_LEVEL_RST;
            cfg_reg.release_level   <= RELEASE_LEVEL_RST;
            cfg_reg.alarm_on_level  <= ALARM_ON_LEVEL_RST;
            cfg_reg.alarm_off_level <= ALARM_OFF_LEVEL_RST;
            cfg_reg.confirm_count   <= CONFIRM_COUNT_RST;
            cfg_reg.off_delay_limit <= OFF_DELAY_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_DETECT_LEVEL:    cfg_reg.detect_level    <= cfg_wdata[LEVEL_W-1:0];
                REG_RELEASE_LEVEL:   cfg_reg.release_level   <= cfg_wdata[LEVEL_W-1:0];
                REG_ALARM_ON_LEVEL:  cfg_reg.alarm_on_level  <= cfg_wdata[LEVEL_W-1:0];
                REG_ALARM_OFF_LEVEL: cfg_reg.alarm_off_level <= cfg_wdata[LEVEL_W-1:0];
                REG_CONFIRM_COUNT:   cfg_reg.confirm_count   <= cfg_wdata[CONFIRM_W-1:0];
                REG_OFF_DELAY_LIMIT: cfg_reg.off_delay_limit <= cfg_wdata[DELAY_W-1:0];
                default:             ;
            endcase
        end
    end

    // Input register: valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_load)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    // Input register: payload
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_sample_reg[0] <= sample_0;
            s1_sample_reg[1] <= sample_1;
            s1_sample_reg[2] <= sample_2;
            s1_sample_reg[3] <= sample_3;
            s1_sample_reg[4] <= sample_4;
            s1_sample_reg[5] <= sample_5;
            s1_sample_reg[6] <= sample_6;
            s1_sample_reg[7] <= sample_7;
            s1_ld_reg        <= light_dark_select;
            s1_odly_reg      <= off_delay_enable;
        end
    end

    psoq_mean #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mean (
        .samples (s1_sample_reg),
        .mean    (mean)
    );

    psoq_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (advance),
        .mean              (mean),
        .light_dark_select (s1_ld_reg),
        .off_delay_enable  (s1_odly_reg),
        .cfg               (cfg_reg),
        .flags             (flags)
    );

    // Result register: valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (!out_stall)
            res_valid_reg <= 1'b0;
    end

    // Result register: payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_flags_reg <= flags;
            res_mean_reg  <= LEVEL_W'(mean);
        end
    end

    assign out_valid    = res_valid_reg;
    assign out_level    = res_flags_reg.out_level;
    assign alarm        = res_flags_reg.alarm;
    assign detect_state = res_flags_reg.detect_state;
    assign mean_value   = res_mean_reg;

`ifndef ASSERT_OFF
    // An accepted transaction always lands in the input register
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s1_load |=> s1_valid_reg)
        else $error("accepted transaction not held in input register");

    // A new result only comes from a held transaction
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s1_valid_reg))
        else $error("result appeared without a transaction");

    // A held transaction that cannot move stays intact
    a_hold_intact: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_sample_reg)))
        else $error("held transaction lost or changed");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Photo sensor output qualifier testbench
// Feeds measurement cycles (eight ADC samples plus the light/dark and
// off-delay switches) through the valid/stall input channel. A built-in
// predictor tracks the debounced detect state, alarm hysteresis and
// off-delay timing. Each result is checked field by field as it leaves the
// block. Several register settings are applied, from the extremes to random
// ones, with different amounts of source gaps and sink back-pressure.
// ----------------------------------------------------------------------------
module testbench;
    import psoq_pkg::*;

    localparam int SAMPLE_W     = 12;
    localparam int FULL_SCALE   = (1 << SAMPLE_W) - 1;
    localparam int RANDOM_ITEMS = 1800;
    localparam int N_PHASES     = 8;
    localparam int CYCLE_LIMIT  = 200000;

    // Indexes that map to no register
    localparam logic [CFG_ADDR_W-1:0] UNMAPPED_IDX_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] UNMAPPED_IDX_HI = 3'd7;

    typedef struct packed {
        logic [SAMPLES_PER_CYCLE-1:0][SAMPLE_W-1:0] samples;
        logic                                       light_dark;
        logic                                       delay_en;
    } measurement_t;

    typedef struct packed {
        logic               out_level;
        logic               alarm;
        logic               detect_state;
        logic [LEVEL_W-1:0] mean;
    } qual_result_t;

    // Where the mean of a run of measurement cycles is placed
    typedef enum logic [2:0] {
        ZONE_DETECT,
        ZONE_RELEASE,
        ZONE_BETWEEN,
        ZONE_EDGE,
        ZONE_NOISE
    } zone_t;

    // DUT connections
    logic                    clk               = 1'b0;
    logic                    rst_n             = 1'b0;
    logic                    cfg_we            = 1'b0;
    logic [CFG_ADDR_W-1:0]   cfg_addr          = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata         = '0;
    logic                    in_valid          = 1'b0;
    logic                    in_stall;
    logic [SAMPLE_W-1:0]     sample_0          = '0;
    logic [SAMPLE_W-1:0]     sample_1          = '0;
    logic [SAMPLE_W-1:0]     sample_2          = '0;
    logic [SAMPLE_W-1:0]     sample_3          = '0;
    logic [SAMPLE_W-1:0]     sample_4          = '0;
    logic [SAMPLE_W-1:0]     sample_5          = '0;
    logic [SAMPLE_W-1:0]     sample_6          = '0;
    logic [SAMPLE_W-1:0]     sample_7          = '0;
    logic                    light_dark_select = 1'b0;
    logic                    off_delay_enable  = 1'b0;
    logic                    out_valid;
    logic                    out_stall         = 1'b0;
    logic                    out_level;
    logic                    alarm;
    logic                    detect_state;
    logic [LEVEL_W-1:0]      mean_value;

    // Register copy
    logic [LEVEL_W-1:0]      detect_lvl    = DETECT_LEVEL_RST;
    logic [LEVEL_W-1:0]      release_lvl   = RELEASE_LEVEL_RST;
    logic [LEVEL_W-1:0]      alarm_on_lvl  = ALARM_ON_LEVEL_RST;
    logic [LEVEL_W-1:0]      alarm_off_lvl = ALARM_OFF_LEVEL_RST;
    logic [CONFIRM_W-1:0]    confirm_cnt   = CONFIRM_COUNT_RST;
    logic [DELAY_W-1:0]      delay_limit   = OFF_DELAY_LIMIT_RST;

    // Qualifier state copy
    logic                    detect_q       = 1'b0;
    logic [RUN_W-1:0]        detect_streak  = '0;
    logic [RUN_W-1:0]        release_streak = '0;
    logic                    alarm_q        = 1'b0;
    logic                    pin_q          = 1'b0;
    logic                    delay_running  = 1'b0;
    logic [DELAY_W-1:0]      delay_ticks    = '0;

    measurement_t            measurement_q[$];
    qual_result_t            expected_results_q[$];
    measurement_t            driven_item;
    qual_result_t            head_result;
    int                      sender_idle_pct    = 0;
    int                      receiver_stall_pct = 0;
    int                      error_count        = 0;
    int                      cycle_count        = 0;
    int                      phase;

    photo_sensor_output_qualifier_unit #(
        .SAMPLE_BITS (SAMPLE_W)
    ) i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .sample_0          (sample_0),
        .sample_1          (sample_1),
        .sample_2          (sample_2),
        .sample_3          (sample_3),
        .sample_4          (sample_4),
        .sample_5          (sample_5),
        .sample_6          (sample_6),
        .sample_7          (sample_7),
        .light_dark_select (light_dark_select),
        .off_delay_enable  (off_delay_enable),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .out_level         (out_level),
        .alarm             (alarm),
        .detect_state      (detect_state),
        .mean_value        (mean_value)
    );

    // Clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Advance the qualifier copy by one measurement cycle
    function automatic qual_result_t qualify_cycle(measurement_t m);
        logic [SAMPLE_W+2:0] sum;
        logic [LEVEL_W-1:0]  avg;
        logic                want;
        qual_result_t        r;
        int                  k;
        sum = '0;
        for (k = 0; k < SAMPLES_PER_CYCLE; k++)
        begin
            sum = sum + (SAMPLE_W+3)'(m.samples[k]);
        end
        avg = LEVEL_W'(sum / SAMPLES_PER_CYCLE);

        // votes: release wins when both levels are met
        if (avg >= release_lvl)
        begin
            release_streak = release_streak + RUN_W'(1);
            detect_streak  = '0;
        end
        else if (avg <= detect_lvl)
        begin
            detect_streak  = detect_streak + RUN_W'(1);
            release_streak = '0;
        end

        // debounce, release checked first
        if (release_streak > RUN_W'(confirm_cnt))
        begin
            detect_q       = 1'b0;
            release_streak = '0;
        end
        else if (detect_streak > RUN_W'(confirm_cnt))
        begin
            detect_q      = 1'b1;
            detect_streak = '0;
        end

        // alarm hysteresis, set wins on overlap
        if (avg <= alarm_on_lvl)
        begin
            alarm_q = 1'b1;
        end
        else if (avg >= alarm_off_lvl)
        begin
            alarm_q = 1'b0;
        end

        want = (m.light_dark == detect_q);

        // off-delay: a running delay counts every enabled cycle
        if (m.delay_en)
        begin
            if (want && !delay_running)
            begin
                pin_q = 1'b1;
            end
            else
            begin
                delay_running = 1'b1;
                delay_ticks   = delay_ticks + DELAY_W'(1);
                if (delay_ticks > delay_limit)
                begin
                    pin_q         = 1'b0;
                    delay_running = 1'b0;
                    delay_ticks   = '0;
                end
            end
        end
        else
        begin
            pin_q = want;
        end

        r.out_level    = pin_q;
        r.alarm        = alarm_q;
        r.detect_state = detect_q;
        r.mean         = avg;
        return r;
    endfunction

    // Spread a target mean over eight samples, remainder chosen at random
    function automatic measurement_t make_measurement(int target, logic ld, logic den);
        measurement_t m;
        int           remaining;
        int           lo;
        int           hi;
        int           k;
        remaining = target * SAMPLES_PER_CYCLE + int'($urandom_range(SAMPLES_PER_CYCLE - 1));
        // the sum cannot go past eight full-scale samples
        if (remaining > FULL_SCALE * SAMPLES_PER_CYCLE)
        begin
            remaining = FULL_SCALE * SAMPLES_PER_CYCLE;
        end
        for (k = 0; k < SAMPLES_PER_CYCLE - 1; k++)
        begin
            lo = remaining - FULL_SCALE * (SAMPLES_PER_CYCLE - 1 - k);
            if (lo < 0)
            begin
                lo = 0;
            end
            hi = (remaining < FULL_SCALE) ? remaining : FULL_SCALE;
            m.samples[k] = SAMPLE_W'($urandom_range(hi, lo));
            remaining    = remaining - int'(m.samples[k]);
        end
        m.samples[SAMPLES_PER_CYCLE-1] = SAMPLE_W'(remaining);
        m.light_dark = ld;
        m.delay_en   = den;
        return m;
    endfunction

    // Pick a mean for the current register setting
    function automatic int pick_mean(zone_t z);
        int v;
        case (z)
            ZONE_DETECT:  v = $urandom_range(detect_lvl, 0);
            ZONE_RELEASE: v = $urandom_range(FULL_SCALE, release_lvl);
            ZONE_BETWEEN:
            begin
                if (int'(release_lvl) > int'(detect_lvl) + 1)
                    v = $urandom_range(release_lvl - 1, detect_lvl + 1);
                else
                    v = $urandom_range(FULL_SCALE);
            end
            ZONE_EDGE:
            begin
                case ($urandom_range(3))
                    0:       v = int'(detect_lvl);
                    1:       v = int'(release_lvl);
                    2:       v = int'(alarm_on_lvl);
                    default: v = int'(alarm_off_lvl);
                endcase
                v = v + int'($urandom_range(2)) - 1;
                if (v < 0)
                    v = 0;
                if (v > FULL_SCALE)
                    v = FULL_SCALE;
            end
            default: v = $urandom_range(FULL_SCALE);
        endcase
        return v;
    endfunction

    // Queue a cycle with all eight samples equal
    task automatic queue_flat_cycle(int level, logic ld, logic den);
        measurement_t m;
        int           k;
        for (k = 0; k < SAMPLES_PER_CYCLE; k++)
        begin
            m.samples[k] = SAMPLE_W'(level);
        end
        m.light_dark = ld;
        m.delay_en   = den;
        measurement_q.push_back(m);
    endtask

    // Queue runs of cycles that each stay in one zone for a random run length
    task automatic queue_measurement_runs(int count);
        zone_t z;
        int    run_left;
        int    pick;
        int    i;
        logic  ld;
        logic  den;
        z        = ZONE_NOISE;
        run_left = 0;
        ld       = 1'($urandom_range(1));
        den      = 1'($urandom_range(1));
        for (i = 0; i < count; i++)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(24, 1);
                pick     = $urandom_range(9);
                if (pick < 3)
                    z = ZONE_DETECT;
                else if (pick < 6)
                    z = ZONE_RELEASE;
                else if (pick == 6)
                    z = ZONE_BETWEEN;
                else if (pick == 7)
                    z = ZONE_EDGE;
                else
                    z = ZONE_NOISE;
                if ($urandom_range(3) == 0)
                    ld = 1'($urandom_range(1));
                if ($urandom_range(2) == 0)
                    den = 1'($urandom_range(1));
            end
            run_left = run_left - 1;
            // occasional switch flips inside a run
            if ($urandom_range(19) == 0)
                ld = ~ld;
            if ($urandom_range(19) == 0)
                den = ~den;
            measurement_q.push_back(make_measurement(pick_mean(z), ld, den));
        end
    endtask

    // One register write, copy updated once the write edge has passed
    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_DETECT_LEVEL:    detect_lvl    = value[LEVEL_W-1:0];
            REG_RELEASE_LEVEL:   release_lvl   = value[LEVEL_W-1:0];
            REG_ALARM_ON_LEVEL:  alarm_on_lvl  = value[LEVEL_W-1:0];
            REG_ALARM_OFF_LEVEL: alarm_off_lvl = value[LEVEL_W-1:0];
            REG_CONFIRM_COUNT:   confirm_cnt   = value[CONFIRM_W-1:0];
            REG_OFF_DELAY_LIMIT: delay_limit   = value[DELAY_W-1:0];
            default:             ;
        endcase
    endtask

    // Write all registers, junk in the unused upper bits
    task automatic program_config(logic [LEVEL_W-1:0] det, logic [LEVEL_W-1:0] rel,
                                  logic [LEVEL_W-1:0] on_lvl, logic [LEVEL_W-1:0] off_lvl,
                                  logic [CONFIRM_W-1:0] conf, logic [DELAY_W-1:0] lim);
        write_reg(REG_DETECT_LEVEL,    {4'($urandom), det});
        write_reg(REG_RELEASE_LEVEL,   {4'($urandom), rel});
        write_reg(REG_ALARM_ON_LEVEL,  {4'($urandom), on_lvl});
        write_reg(REG_ALARM_OFF_LEVEL, {4'($urandom), off_lvl});
        write_reg(REG_CONFIRM_COUNT,   {12'($urandom), conf});
        write_reg(REG_OFF_DELAY_LIMIT, lim);
    endtask

    // Hold off until the block has nothing in flight
    task automatic wait_drained();
        while (measurement_q.size() != 0 || in_valid || expected_results_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Input driver: prediction at accept, next transaction when the slot frees
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results_q.push_back(qualify_cycle(driven_item));
            end
            if (!in_valid || !in_stall)
            begin
                if (measurement_q.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    driven_item        = measurement_q.pop_front();
                    in_valid          <= 1'b1;
                    sample_0          <= driven_item.samples[0];
                    sample_1          <= driven_item.samples[1];
                    sample_2          <= driven_item.samples[2];
                    sample_3          <= driven_item.samples[3];
                    sample_4          <= driven_item.samples[4];
                    sample_5          <= driven_item.samples[5];
                    sample_6          <= driven_item.samples[6];
                    sample_7          <= driven_item.samples[7];
                    light_dark_select <= driven_item.light_dark;
                    off_delay_enable  <= driven_item.delay_en;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor and sink back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got out=%b alarm=%b det=%b mean=%0d",
                             $time, out_level, alarm, detect_state, mean_value);
                    error_count++;
                end
                else
                begin
                    head_result = expected_results_q.pop_front();
                    if (out_level !== head_result.out_level)
                    begin
                        $display("%0t: out_level expected %b, got %b",
                                 $time, head_result.out_level, out_level);
                        error_count++;
                    end
                    if (alarm !== head_result.alarm)
                    begin
                        $display("%0t: alarm expected %b, got %b",
                                 $time, head_result.alarm, alarm);
                        error_count++;
                    end
                    if (detect_state !== head_result.detect_state)
                    begin
                        $display("%0t: detect_state expected %b, got %b",
                                 $time, head_result.detect_state, detect_state);
                        error_count++;
                    end
                    if (mean_value !== head_result.mean)
                    begin
                        $display("%0t: mean_value expected %0d, got %0d",
                                 $time, head_result.mean, mean_value);
                        error_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("photo_sensor_output_qualifier_unit: mismatch");
            $finish;
        end
    end

    // Stimulus sequence
    initial
    begin
        measurement_t m;
        int           k;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed cycles at the reset setting
        queue_flat_cycle(0, 1'b0, 1'b0);
        queue_flat_cycle(FULL_SCALE, 1'b1, 1'b1);
        for (k = 0; k < SAMPLES_PER_CYCLE; k++)
        begin
            m.samples[k] = (k < 4) ? 12'hAAA : 12'h555;
        end
        m.light_dark = 1'b1;
        m.delay_en   = 1'b0;
        measurement_q.push_back(m);
        // sum one short of full scale truncates down
        for (k = 0; k < SAMPLES_PER_CYCLE; k++)
        begin
            m.samples[k] = (k == 0) ? SAMPLE_W'(FULL_SCALE - 1) : SAMPLE_W'(FULL_SCALE);
        end
        m.light_dark = 1'b0;
        m.delay_en   = 1'b1;
        measurement_q.push_back(m);
        // remainder of seven truncates onto the detect level
        for (k = 0; k < SAMPLES_PER_CYCLE; k++)
        begin
            m.samples[k] = (k == 0) ? SAMPLE_W'(DETECT_LEVEL_RST + 7) : DETECT_LEVEL_RST;
        end
        m.light_dark = 1'b1;
        m.delay_en   = 1'b0;
        measurement_q.push_back(m);
        repeat (3) queue_flat_cycle(int'(DETECT_LEVEL_RST), 1'b1, 1'b0);
        // between the levels: no vote, runs hold
        repeat (2) queue_flat_cycle(2550, 1'b1, 1'b0);
        queue_flat_cycle(int'(DETECT_LEVEL_RST), 1'b1, 1'b1);
        // release run with off-delay holding the pin
        repeat (5) queue_flat_cycle(int'(RELEASE_LEVEL_RST), 1'b0, 1'b1);
        queue_flat_cycle(int'(ALARM_ON_LEVEL_RST), 1'b1, 1'b1);
        queue_flat_cycle(int'(ALARM_OFF_LEVEL_RST), 1'b0, 1'b1);
        queue_flat_cycle(ALARM_ON_LEVEL_RST - 1, 1'b0, 1'b0);
        queue_flat_cycle(ALARM_OFF_LEVEL_RST + 1, 1'b1, 1'b0);
        queue_flat_cycle(ALARM_ON_LEVEL_RST + 1, 1'b1, 1'b1);

        // random phases; each starts with the block drained
        for (phase = 0; phase < N_PHASES; phase++)
        begin
            wait_drained();
            case (phase)
                0: program_config(2000, 2100, 2050, 2200, 0, 0);
                1: program_config(1500, 3000, 1400, 1600, 15, 5);
                2:
                begin
                    // confirm drops from its maximum with runs stored
                    program_config(0, LEVEL_W'(FULL_SCALE), 0, LEVEL_W'(FULL_SCALE), 1, 1);
                    write_reg(UNMAPPED_IDX_LO, 16'($urandom));
                    write_reg(UNMAPPED_IDX_HI, 16'($urandom));
                end
                3: program_config(LEVEL_W'(FULL_SCALE), 0, LEVEL_W'(FULL_SCALE), 0, 2, 16'hFFFF);
                4: program_config(3000, 1000, 2000, 2000, 4, 16'hFFFE);
                default:
                    program_config(LEVEL_W'($urandom_range(FULL_SCALE)),
                                   LEVEL_W'($urandom_range(FULL_SCALE)),
                                   LEVEL_W'($urandom_range(FULL_SCALE)),
                                   LEVEL_W'($urandom_range(FULL_SCALE)),
                                   CONFIRM_W'($urandom_range(15)),
                                   DELAY_W'($urandom_range(40)));
            endcase
            case (phase % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 69;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 69;
                end
                default:
                begin
                    sender_idle_pct    = 8;
                    receiver_stall_pct = 8;
                end
            endcase
            @(negedge clk);
            queue_measurement_runs(RANDOM_ITEMS / N_PHASES);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("photo_sensor_output_qualifier_unit: match");
        else
            $display("photo_sensor_output_qualifier_unit: mismatch");
        $finish;
    end

endmodule

// ===== photo_sensor_output_qualifier_unit.f =====
hw/rtl/psoq_pkg.sv
hw/rtl/psoq_mean.sv
hw/rtl/psoq_core.sv
hw/rtl/photo_sensor_output_qualifier_unit.sv
tb/testbench.sv
